### design/sspp_pkg.sv
// ----------------------------------------------------------------------------
// Servo status packet parser package
// Types, codes and defaults shared by the status reply parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sspp_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 8;
   localparam int PAYLOAD_BYTES       = 8;

   localparam logic [7:0]  SYNC_BYTE             = 8'hFF;
   localparam logic [7:0]  EXPECTED_ID_RESET     = 8'd1;
   localparam logic [3:0]  PAYLOAD_LEN_RESET     = 4'd0;
   localparam logic [15:0] TIMEOUT_TICKS_RESET   = 16'd20;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_EXPECTED_ID = 2'd0;
   localparam logic [1:0] CSR_PAYLOAD_LEN = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT     = 2'd2;

   typedef enum logic [1:0] {
      REQ_ARM  = 2'd0,
      REQ_BYTE = 2'd1,
      REQ_TICK = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      OUT_OK      = 3'd0,
      OUT_ID      = 3'd1,
      OUT_LEN     = 3'd2,
      OUT_STATUS  = 3'd3,
      OUT_CSUM    = 3'd4,
      OUT_TIMEOUT = 3'd5
   } outcome_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HUNT   = 3'd1,
      PH_ID     = 3'd2,
      PH_LEN    = 3'd3,
      PH_STATUS = 3'd4,
      PH_DATA   = 3'd5,
      PH_CSUM   = 3'd6
   } phase_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [7:0]   rx_byte;
   } req_item_type;

   typedef struct packed {
      outcome_type outcome;
      logic [63:0] payload_data;
      logic [3:0]  payload_count;
      logic [7:0]  reply_status;
   } rsp_item_type;

endpackage : sspp_pkg

`default_nettype wire

### design/servo_status_packet_parser.sv
// ----------------------------------------------------------------------------
// Servo status packet parser
// Hunts for a status reply after arming, checks its header and checksum and
// reports one outcome per reply, or a timeout.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------
//  req_    | in        | req_valid/stall    | arm, received byte or tick
//  rsp_    | out       | rsp_valid/stall    | outcome, payload, count, status
//  csr_    | in        | csr_valid/ready    | register index and write data
//
//  One request transfer is taken in every cycle while req_stall is low; its
//  result, if it has one, is registered in the output or the skid register.
//  The parser state updates at the edge where a request is taken, so each
//  header, payload and checksum byte of a reply is parsed as it is taken.
//  When the consumer stalls, one further result is held in a skid register;
//  while that register is occupied req_stall is high.
//  Reset is synchronous and clears control state only; the payload store
//  is not cleared, as bytes beyond the received count are masked on output.
//
`default_nettype none

module servo_status_packet_parser #(
   parameter int MaxPayload = sspp_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,

   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire sspp_pkg::req_item_type req_data,

   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output sspp_pkg::rsp_item_type rsp_data,

   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [1:0]            csr_index,
   input  wire [15:0]           csr_wdata
);

   localparam int StoreBits = MaxPayload * 8;

   // Configuration registers.
   logic [7:0]  cfg_id_ff;
   logic [3:0]  cfg_len_ff;
   logic [15:0] cfg_timeout_ff;

   // Parser state.
   sspp_pkg::phase_type phase_ff, phase_in;
   logic           last_was_ff_ff, last_was_ff_in;
   logic [7:0]     reply_id_ff, reply_id_in;
   logic [7:0]     reply_length_ff, reply_length_in;
   logic [7:0]     status_byte_ff, status_byte_in;
   logic [3:0]     byte_index_ff, byte_index_in;
   logic [7:0]     running_sum_ff, running_sum_in;
   logic [15:0]    tick_count_ff, tick_count_in;
   logic [StoreBits-1:0] payload_store_ff;

   // Output register and skid register.
   logic                  rsp_valid_ff, rsp_valid_in;
   sspp_pkg::rsp_item_type rsp_data_ff, rsp_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   sspp_pkg::rsp_item_type skid_data_ff, skid_data_in;

   // Decode of the request being taken this cycle.
   logic        req_fire;
   logic        armed;
   logic        byte_fire;
   logic        tick_fire;
   logic        is_sync;
   logic [16:0] tick_next;
   logic        tick_expired;
   logic        hdr_fail;
   sspp_pkg::outcome_type hdr_code;
   logic [3:0]  index_next;
   logic        data_last;
   logic        store_wr;
   logic [63:0] store_wide;
   logic [63:0] payload_masked;

   logic                   res_valid;
   sspp_pkg::rsp_item_type res;
   logic                   rsp_pop;

   assign req_fire  = req_valid & ~req_stall;
   assign armed     = (phase_ff != sspp_pkg::PH_IDLE);
   assign byte_fire = req_fire & armed & (req_data.req_type == sspp_pkg::REQ_BYTE);
   assign tick_fire = req_fire & armed & (req_data.req_type == sspp_pkg::REQ_TICK);
   assign is_sync   = (req_data.rx_byte == sspp_pkg::SYNC_BYTE);

   assign tick_next    = {1'b0, tick_count_ff} + 17'd1;
   assign tick_expired = (tick_next >= {1'b0, cfg_timeout_ff});

   assign index_next = byte_index_ff + 4'd1;
   assign data_last  = (index_next >= cfg_len_ff);
   assign store_wr   = byte_fire & (phase_ff == sspp_pkg::PH_DATA);

   // Header checks, taken when the status byte arrives; the first failure
   // names the outcome, and an expected length beyond the store size is
   // reported as a length mismatch.
   always_comb begin
      hdr_fail = 1'b1;
      hdr_code = sspp_pkg::OUT_LEN;
      priority if (reply_id_ff != cfg_id_ff) begin
         hdr_code = sspp_pkg::OUT_ID;
      end else if ({1'b0, reply_length_ff} != ({5'd0, cfg_len_ff} + 9'd2)) begin
         hdr_code = sspp_pkg::OUT_LEN;
      end else if (req_data.rx_byte != 8'd0) begin
         hdr_code = sspp_pkg::OUT_STATUS;
      end else if (cfg_len_ff > 4'(MaxPayload)) begin
         hdr_code = sspp_pkg::OUT_LEN;
      end else begin
         hdr_fail = 1'b0;
      end
   end

   // Bytes beyond the received count are never written in this reply and
   // read as zero.
   assign store_wide = 64'(payload_store_ff);
   always_comb begin
      payload_masked = '0;
      for (int i = 0; i < sspp_pkg::PAYLOAD_BYTES; i++) begin
         if (4'(i) < cfg_len_ff) begin
            payload_masked[8*i +: 8] = store_wide[8*i +: 8];
         end
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (req_fire) begin
         unique case (req_data.req_type)
            sspp_pkg::REQ_ARM: begin
               phase_in = sspp_pkg::PH_HUNT;
            end
            sspp_pkg::REQ_TICK: begin
               if (armed && tick_expired) begin
                  phase_in = sspp_pkg::PH_IDLE;
               end
            end
            sspp_pkg::REQ_BYTE: begin
               unique case (phase_ff)
                  sspp_pkg::PH_IDLE: begin
                     phase_in = sspp_pkg::PH_IDLE;
                  end
                  sspp_pkg::PH_HUNT: begin
                     if (last_was_ff_ff && is_sync) begin
                        phase_in = sspp_pkg::PH_ID;
                     end
                  end
                  sspp_pkg::PH_ID: begin
                     phase_in = sspp_pkg::PH_LEN;
                  end
                  sspp_pkg::PH_LEN: begin
                     phase_in = sspp_pkg::PH_STATUS;
                  end
                  sspp_pkg::PH_STATUS: begin
                     if (hdr_fail) begin
                        phase_in = sspp_pkg::PH_IDLE;
                     end else if (cfg_len_ff == 4'd0) begin
                        phase_in = sspp_pkg::PH_CSUM;
                     end else begin
                        phase_in = sspp_pkg::PH_DATA;
                     end
                  end
                  sspp_pkg::PH_DATA: begin
                     if (data_last) begin
                        phase_in = sspp_pkg::PH_CSUM;
                     end
                  end
                  sspp_pkg::PH_CSUM: begin
                     phase_in = sspp_pkg::PH_IDLE;
                  end
                  default: begin
                     phase_in = sspp_pkg::PH_IDLE;
                  end
               endcase
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Datapath state and the result of the request taken this cycle.
   always_comb begin
      last_was_ff_in  = last_was_ff_ff;
      reply_id_in     = reply_id_ff;
      reply_length_in = reply_length_ff;
      status_byte_in  = status_byte_ff;
      byte_index_in   = byte_index_ff;
      running_sum_in  = running_sum_ff;
      tick_count_in   = tick_count_ff;
      res_valid       = 1'b0;
      res.outcome       = sspp_pkg::OUT_OK;
      res.payload_data  = '0;
      res.payload_count = '0;
      res.reply_status  = status_byte_ff;

      if (req_fire && req_data.req_type == sspp_pkg::REQ_ARM) begin
         last_was_ff_in  = 1'b0;
         reply_id_in     = '0;
         reply_length_in = '0;
         status_byte_in  = '0;
         byte_index_in   = '0;
         running_sum_in  = '0;
         tick_count_in   = '0;
      end else if (tick_fire) begin
         tick_count_in = tick_next[15:0];
         if (tick_expired) begin
            res_valid   = 1'b1;
            res.outcome = sspp_pkg::OUT_TIMEOUT;
         end
      end else if (byte_fire) begin
         unique case (phase_ff)
            sspp_pkg::PH_HUNT: begin
               if (!(last_was_ff_ff && is_sync)) begin
                  last_was_ff_in = is_sync;
               end
            end
            sspp_pkg::PH_ID: begin
               reply_id_in = req_data.rx_byte;
            end
            sspp_pkg::PH_LEN: begin
               reply_length_in = req_data.rx_byte;
            end
            sspp_pkg::PH_STATUS: begin
               status_byte_in   = req_data.rx_byte;
               res.reply_status = req_data.rx_byte;
               if (hdr_fail) begin
                  res_valid   = 1'b1;
                  res.outcome = hdr_code;
               end else begin
                  // Status is zero here, so the sum covers id and length.
                  running_sum_in = reply_id_ff + reply_length_ff;
                  byte_index_in  = '0;
               end
            end
            sspp_pkg::PH_DATA: begin
               running_sum_in = running_sum_ff + req_data.rx_byte;
               byte_index_in  = index_next;
            end
            sspp_pkg::PH_CSUM: begin
               res_valid = 1'b1;
               if (req_data.rx_byte != ~running_sum_ff) begin
                  res.outcome = sspp_pkg::OUT_CSUM;
               end else begin
                  res.outcome       = sspp_pkg::OUT_OK;
                  res.payload_data  = payload_masked;
                  res.payload_count = cfg_len_ff;
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   // Output register with one skid entry behind it.
   assign rsp_pop = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || rsp_pop) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = res_valid;
            rsp_data_in  = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res;
      end
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_id_ff      <= sspp_pkg::EXPECTED_ID_RESET;
         cfg_len_ff     <= sspp_pkg::PAYLOAD_LEN_RESET;
         cfg_timeout_ff <= sspp_pkg::TIMEOUT_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sspp_pkg::CSR_EXPECTED_ID: cfg_id_ff      <= csr_wdata[7:0];
            sspp_pkg::CSR_PAYLOAD_LEN: cfg_len_ff     <= csr_wdata[3:0];
            sspp_pkg::CSR_TIMEOUT:     cfg_timeout_ff <= csr_wdata;
            default: begin
               cfg_id_ff <= cfg_id_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= sspp_pkg::PH_IDLE;
         last_was_ff_ff  <= 1'b0;
         reply_id_ff     <= '0;
         reply_length_ff <= '0;
         status_byte_ff  <= '0;
         byte_index_ff   <= '0;
         running_sum_ff  <= '0;
         tick_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         last_was_ff_ff  <= last_was_ff_in;
         reply_id_ff     <= reply_id_in;
         reply_length_ff <= reply_length_in;
         status_byte_ff  <= status_byte_in;
         byte_index_ff   <= byte_index_in;
         running_sum_ff  <= running_sum_in;
         tick_count_ff   <= tick_count_in;
         rsp_valid_ff    <= rsp_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   // Payload bytes land in the slot named by the byte index.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxPayload; i++) begin
         if (store_wr && byte_index_ff == 4'(i)) begin
            payload_store_ff[8*i +: 8] <= req_data.rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   // The skid entry is only ever filled behind a stalled output register.
   a_skid_behind_output : assert property (
      @(posedge clock) disable iff (reset) skid_valid_ff |-> rsp_valid_ff
   ) else $error("skid entry held without a result in the output register");

   // A disarmed parser produces no result.
   a_idle_silent : assert property (
      @(posedge clock) disable iff (reset) (phase_ff == sspp_pkg::PH_IDLE) |-> !res_valid
   ) else $error("result produced while not armed");

   // Every outcome disarms the parser.
   a_result_disarms : assert property (
      @(posedge clock) disable iff (reset) res_valid |=> (phase_ff == sspp_pkg::PH_IDLE)
   ) else $error("parser still armed after an outcome");

   // The payload index never runs past the store.
   a_index_bound : assert property (
      @(posedge clock) disable iff (reset) byte_index_ff <= 4'(MaxPayload)
   ) else $error("payload index beyond store size");

   // A good reply reports exactly the configured number of payload bytes.
   a_ok_count : assert property (
      @(posedge clock) disable iff (reset)
         (res_valid && res.outcome == sspp_pkg::OUT_OK) |-> (res.payload_count == cfg_len_ff)
   ) else $error("payload count differs from configured length");

endmodule : servo_status_packet_parser

`default_nettype wire

### tb/servo_status_packet_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo status packet parser testbench
// Feeds arm requests, reply bytes and ticks to the parser under random gaps
// and consumer stalls, and compares every reply outcome with a cycle-free
// model of the parser that is kept in step with the accepted transfers.
// ----------------------------------------------------------------------------

// Tracks the parser state and the outcomes that are still owed by the block.
class status_reply_book;
   localparam logic [1:0] UNUSED_REQ = 2'd3;

   int                     errors;
   sspp_pkg::rsp_item_type owed_outcomes[$];

   logic [7:0]  want_id;
   logic [3:0]  want_len;
   logic [15:0] tick_limit;

   sspp_pkg::phase_type phase;
   bit          saw_ff;
   logic [7:0]  id_seen;
   logic [7:0]  len_seen;
   logic [7:0]  status_seen;
   logic [63:0] payload;
   logic [3:0]  data_idx;
   logic [7:0]  sum;
   logic [15:0] ticks;

   function new();
      errors     = 0;
      want_id    = sspp_pkg::EXPECTED_ID_RESET;
      want_len   = sspp_pkg::PAYLOAD_LEN_RESET;
      tick_limit = sspp_pkg::TIMEOUT_TICKS_RESET;
      phase      = sspp_pkg::PH_IDLE;
      clear();
   endfunction

   function void clear();
      saw_ff      = 1'b0;
      id_seen     = '0;
      len_seen    = '0;
      status_seen = '0;
      payload     = '0;
      data_idx    = '0;
      sum         = '0;
      ticks       = '0;
   endfunction

   function int pending();
      return owed_outcomes.size();
   endfunction

   function void write_register(logic [1:0] index, logic [15:0] value);
      case (index)
         sspp_pkg::CSR_EXPECTED_ID: want_id    = value[7:0];
         sspp_pkg::CSR_PAYLOAD_LEN: want_len   = value[3:0];
         sspp_pkg::CSR_TIMEOUT:     tick_limit = value;
         default: ;
      endcase
   endfunction

   function void conclude(sspp_pkg::outcome_type code, logic [63:0] data,
                          logic [3:0] count);
      sspp_pkg::rsp_item_type r;
      r.outcome       = code;
      r.payload_data  = data;
      r.payload_count = count;
      r.reply_status  = status_seen;
      owed_outcomes.push_back(r);
      phase = sspp_pkg::PH_IDLE;
   endfunction

   function void note_request(sspp_pkg::req_item_type it);
      logic [1:0]  kind;
      logic [7:0]  b;
      logic [16:0] next;
      kind = it.req_type;
      b    = it.rx_byte;
      if (kind == sspp_pkg::REQ_ARM) begin
         clear();
         phase = sspp_pkg::PH_HUNT;
         return;
      end
      if (kind == UNUSED_REQ || phase == sspp_pkg::PH_IDLE) return;
      if (kind == sspp_pkg::REQ_TICK) begin
         next  = {1'b0, ticks} + 17'd1;
         ticks = next[15:0];
         if (next >= {1'b0, tick_limit}) conclude(sspp_pkg::OUT_TIMEOUT, '0, '0);
         return;
      end
      case (phase)
         sspp_pkg::PH_HUNT: begin
            if (saw_ff && b == sspp_pkg::SYNC_BYTE) phase = sspp_pkg::PH_ID;
            else saw_ff = (b == sspp_pkg::SYNC_BYTE);
         end
         sspp_pkg::PH_ID: begin
            id_seen = b;
            phase   = sspp_pkg::PH_LEN;
         end
         sspp_pkg::PH_LEN: begin
            len_seen = b;
            phase    = sspp_pkg::PH_STATUS;
         end
         sspp_pkg::PH_STATUS: begin
            // All three header bytes are in; the first failing check wins.
            status_seen = b;
            if (id_seen != want_id) begin
               conclude(sspp_pkg::OUT_ID, '0, '0);
            end else if (len_seen != {4'd0, want_len} + 8'd2) begin
               conclude(sspp_pkg::OUT_LEN, '0, '0);
            end else if (status_seen != 8'd0) begin
               conclude(sspp_pkg::OUT_STATUS, '0, '0);
            end else if (want_len > sspp_pkg::MAX_PAYLOAD_DEFAULT) begin
               conclude(sspp_pkg::OUT_LEN, '0, '0);
            end else begin
               sum      = id_seen + len_seen + status_seen;
               data_idx = '0;
               phase    = (want_len == 4'd0) ? sspp_pkg::PH_CSUM : sspp_pkg::PH_DATA;
            end
         end
         sspp_pkg::PH_DATA: begin
            payload  = payload | ({56'd0, b} << (8 * data_idx[2:0]));
            sum      = sum + b;
            data_idx = data_idx + 4'd1;
            if (data_idx >= want_len) phase = sspp_pkg::PH_CSUM;
         end
         sspp_pkg::PH_CSUM: begin
            if (b != ~sum) conclude(sspp_pkg::OUT_CSUM, '0, '0);
            else conclude(sspp_pkg::OUT_OK, payload, want_len);
         end
         default: phase = sspp_pkg::PH_IDLE;
      endcase
   endfunction

   function void check_outcome(sspp_pkg::rsp_item_type got);
      sspp_pkg::rsp_item_type want;
      if (owed_outcomes.size() == 0) begin
         $error("result with nothing owed: outcome %0d, status %h", got.outcome,
                got.reply_status);
         errors++;
         return;
      end
      want = owed_outcomes.pop_front();
      if (got.outcome !== want.outcome) begin
         $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
         errors++;
      end
      if (got.payload_data !== want.payload_data) begin
         $error("payload_data: expected %h, got %h", want.payload_data, got.payload_data);
         errors++;
      end
      if (got.payload_count !== want.payload_count) begin
         $error("payload_count: expected %0d, got %0d", want.payload_count,
                got.payload_count);
         errors++;
      end
      if (got.reply_status !== want.reply_status) begin
         $error("reply_status: expected %h, got %h", want.reply_status, got.reply_status);
         errors++;
      end
   endfunction
endclass

module servo_status_packet_parser_test;

   // Request code that the parser must ignore.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   // Length of the deliberate consumer hold-off, in clock cycles.
   localparam int HOLD_CYCLES = 300;
   // The random part runs through this many register settings.
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_ITEMS = 145;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   sspp_pkg::req_item_type req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   sspp_pkg::rsp_item_type rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [1:0]             csr_index;
   logic [15:0]            csr_wdata;

   status_reply_book book;

   // Idling knobs, changed from phase to phase by the stimulus process.
   int send_idle_pct = 30;
   int stall_pct     = 30;
   int items_sent    = 0;
   bit hold_request  = 1'b0;

   servo_status_packet_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous ceiling on the run; the slowest legal run is a small fraction
   // of this even with every stall at its longest.
   initial begin
      #10ms;
      $display("DONE: errors detected");
      $finish;
   end

   // Length of an idle stretch: none at all most of the time when pct is
   // low, otherwise mostly short gaps with the odd long one.
   function automatic int pick_gap(int pct);
      int r;
      if ($urandom_range(0, 99) >= pct) return 0;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(1, 3);
      if (r < 9) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // Every transfer is observed here, on the rising edge, from the values
   // that the block itself sees at that edge. A result can never stem from
   // a request taken at the same edge, so the order of the two checks is
   // immaterial.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) book.check_outcome(rsp_data);
         if (req_valid && !req_stall) book.note_request(req_data);
         if (csr_valid && csr_ready) book.write_register(csr_index, csr_wdata);
      end
   end

   // Consumer: random stall runs, plus one long hold-off on request. The
   // hold-off is counted here so that the producer keeps offering requests
   // meanwhile and the block has to back-pressure its input.
   initial begin : consumer
      int run;
      bit level;
      rsp_stall = 1'b0;
      run       = 0;
      level     = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            if (run == 0) begin
               run   = pick_gap(stall_pct);
               level = (run != 0);
               if (!level) run = $urandom_range(1, 16);
            end
            rsp_stall <= level;
            run--;
         end
      end
   end

   // One request transfer. Valid is left high after the transfer so that
   // back-to-back requests need no gap; it is dropped only for an idle
   // stretch or by settle.
   task automatic push_request(input logic [1:0] kind, input logic [7:0] value);
      int gap;
      sspp_pkg::req_item_type it;
      gap        = pick_gap(send_idle_pct);
      it.req_type = sspp_pkg::req_kind_type'(kind);
      it.rx_byte  = value;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // A complete reply: two sync bytes, header, payload and checksum. The
   // checksum is the inverted byte sum of everything after the sync bytes,
   // optionally spoilt by a nonzero mask.
   task automatic send_reply(input logic [7:0] id_b, input logic [7:0] len_b,
                             input logic [7:0] st_b, input int n_data, input bit bad_sum);
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] spoil;
      sum   = id_b + len_b + st_b;
      spoil = bad_sum ? 8'($urandom_range(1, 255)) : 8'd0;
      push_request(sspp_pkg::REQ_BYTE, sspp_pkg::SYNC_BYTE);
      push_request(sspp_pkg::REQ_BYTE, sspp_pkg::SYNC_BYTE);
      push_request(sspp_pkg::REQ_BYTE, id_b);
      push_request(sspp_pkg::REQ_BYTE, len_b);
      push_request(sspp_pkg::REQ_BYTE, st_b);
      for (int i = 0; i < n_data; i++) begin
         b   = 8'($urandom);
         sum = sum + b;
         push_request(sspp_pkg::REQ_BYTE, b);
      end
      push_request(sspp_pkg::REQ_BYTE, ~sum ^ spoil);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [7:0] id_w, input logic [3:0] len_w,
                            input logic [15:0] limit);
      write_csr(sspp_pkg::CSR_EXPECTED_ID, {8'd0, id_w});
      write_csr(sspp_pkg::CSR_PAYLOAD_LEN, {12'd0, len_w});
      write_csr(sspp_pkg::CSR_TIMEOUT, limit);
   endtask

   // Stops offering requests and waits until every owed outcome has been
   // taken, then lets the given number of extra cycles pass as a margin; a
   // request without a result leaves nothing behind in the output registers.
   task automatic settle(input int extra);
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // One armed exchange. Most are well-formed replies with random content so
   // that the payload and checksum stages are reached; the rest carry a
   // broken header field or checksum, send ticks toward the timeout, stop half-way or
   // are plain noise.
   task automatic run_sequence(input logic [7:0] id_w, input logic [3:0] len_w,
                               input logic [15:0] limit);
      int pick;
      int n_data;
      int n_ticks;
      logic [7:0] len_b;
      pick    = $urandom_range(0, 99);
      n_data  = (len_w > sspp_pkg::MAX_PAYLOAD_DEFAULT) ? sspp_pkg::MAX_PAYLOAD_DEFAULT
                                                        : int'(len_w);
      n_ticks = (limit == 16'd0) ? 1 : ((limit <= 16'd40) ? int'(limit) : 4);
      len_b   = {4'd0, len_w} + 8'd2;
      push_request(sspp_pkg::REQ_ARM, 8'($urandom));
      // Line noise ahead of the sync bytes; never a sync byte itself.
      repeat ($urandom_range(0, 2))
         push_request(sspp_pkg::REQ_BYTE, 8'($urandom_range(0, 254)));
      if (pick < 60) begin
         if ($urandom_range(0, 5) == 0) push_request(sspp_pkg::REQ_TICK, 8'($urandom));
         send_reply(id_w, len_b, 8'h00, n_data, 1'b0);
      end else if (pick < 76) begin
         case ($urandom_range(0, 3))
            0: send_reply(id_w ^ 8'($urandom_range(1, 255)), len_b, 8'h00, n_data, 1'b0);
            1: send_reply(id_w, len_b ^ 8'($urandom_range(1, 255)), 8'h00, n_data, 1'b0);
            2: send_reply(id_w, len_b, 8'($urandom_range(1, 255)), n_data, 1'b0);
            default: send_reply(id_w, len_b, 8'h00, n_data, 1'b1);
         endcase
      end else if (pick < 86) begin
         repeat (n_ticks) push_request(sspp_pkg::REQ_TICK, 8'($urandom));
      end else if (pick < 93) begin
         // Reply cut short; the next arm restarts the parser mid-reply.
         push_request(sspp_pkg::REQ_BYTE, sspp_pkg::SYNC_BYTE);
         push_request(sspp_pkg::REQ_BYTE, sspp_pkg::SYNC_BYTE);
         repeat ($urandom_range(1, 4)) push_request(sspp_pkg::REQ_BYTE, 8'($urandom));
      end else begin
         repeat ($urandom_range(1, 6)) push_request(2'($urandom), 8'($urandom));
      end
   endtask

   initial begin : stimulus
      logic [7:0]  id_w;
      logic [3:0]  len_w;
      logic [15:0] limit;
      int          target;

      book      = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. While the parser is not armed, bytes, ticks and the
      // unused request code are all dropped without a result.
      send_idle_pct = 20;
      stall_pct     = 20;
      push_request(sspp_pkg::REQ_BYTE, 8'hFF);
      push_request(sspp_pkg::REQ_TICK, 8'h00);
      push_request(REQ_UNUSED, 8'hA5);
      // Reply with no payload under the reset settings: the checksum byte
      // follows the status byte directly.
      push_request(sspp_pkg::REQ_ARM, 8'h00);
      send_reply(sspp_pkg::EXPECTED_ID_RESET, 8'd2, 8'h00, 0, 1'b0);
      settle(4);
      // Largest id that the bench uses, full payload and the longest timeout.
      configure(8'd254, 4'd8, 16'hFFFF);
      push_request(sspp_pkg::REQ_ARM, 8'hFF);
      send_reply(8'd254, 8'd10, 8'h00, 8, 1'b0);
      settle(4);
      // A short wait that runs out.
      configure(8'd0, 4'd0, 16'd3);
      push_request(sspp_pkg::REQ_ARM, 8'h00);
      repeat (3) push_request(sspp_pkg::REQ_TICK, 8'h00);
      settle(4);

      // Back-pressure: every arm-and-tick pair times out at once, while the
      // consumer holds off for a long stretch, so the output and skid
      // registers fill and the block has to stall its request input.
      configure(8'd0, 4'd0, 16'd1);
      hold_request  = 1'b1;
      send_idle_pct = 0;
      repeat (12) begin
         push_request(sspp_pkg::REQ_ARM, 8'($urandom));
         push_request(sspp_pkg::REQ_TICK, 8'($urandom));
      end
      settle(4);

      // Random part, one register setting per phase. The first four cover
      // the extremes, a payload length beyond what the parser can store and
      // a zero timeout, which expires on the very first tick.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         id_w  = 8'($urandom_range(0, 254));
         len_w = 4'($urandom_range(0, 8));
         limit = 16'($urandom_range(2, 40));
         case (p)
            0: begin
               id_w  = 8'd0;
               len_w = 4'd0;
               limit = 16'd1;
            end
            1: begin
               id_w  = 8'd254;
               len_w = 4'd8;
               limit = 16'hFFFF;
            end
            2: begin
               len_w = 4'($urandom_range(9, 15));
               limit = sspp_pkg::TIMEOUT_TICKS_RESET;
            end
            3: limit = 16'd0;
            default: ;
         endcase
         configure(id_w, len_w, limit);
         // Some phases run with no idling at all on one side or the other.
         send_idle_pct = (p % 4 == 1) ? 0 : $urandom_range(10, 50);
         stall_pct     = (p % 4 == 2) ? 0 : $urandom_range(10, 50);
         target        = items_sent + PHASE_ITEMS;
         while (items_sent < target) run_sequence(id_w, len_w, limit);
         settle(4);
      end

      settle(8);
      if (book.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### servo_status_packet_parser.f
design/sspp_pkg.sv
design/servo_status_packet_parser.sv
tb/servo_status_packet_parser_test.sv
